/* rtl/gmps_pkg.sv */
`timescale 1ns / 1ps

package gmps_pkg;

    // Default sizing
    localparam int MAX_SIZE_DEF  = 64;
    localparam int SUM_WIDTH_DEF = 24;

    // Fixed field widths
    localparam int CELL_WIDTH      = 16;
    localparam int GRID_SIZE_WIDTH = 7;
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;

    // Register map, word index taken from paddr[2]
    localparam logic REG_GRID_SIZE     = 1'b0;
    localparam logic REG_NEIGHBOR_MODE = 1'b1;

    // Reset values of the registers
    localparam logic [GRID_SIZE_WIDTH-1:0] GRID_SIZE_RESET = 7'd5;
    localparam logic                       MODE_RESET      = 1'b0;

    // Neighbor modes
    typedef enum logic {
        MODE_LEFT_UP   = 1'b0,
        MODE_DIAG_ZERO = 1'b1
    } gmps_mode_t;

    // Position flags of the cell held in the compute stage
    typedef struct packed {
        logic first_col;
        logic first_row;
        logic last_cell;
    } gmps_ctl_t;

endpackage

/* rtl/gmps_ram.sv */
`timescale 1ns / 1ps

module gmps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/grid_max_path_sum_core.sv */
`timescale 1ns / 1ps

// Best path sum over a square grid, one cell per word.
// s_ channel: cells in raster order (row by row, left to right), s_tdata holds
//   the signed 16-bit cell weight.
// m_ channel: one word per cell, m_tdata holds the signed best path sum that
//   ends at that cell, m_tlast marks the bottom-right cell of the grid.
// APB port: register 0 (0x0) grid_size, register 1 (0x4) neighbor_mode.
//   Write them only while the stream is idle.
// Throughput: one cell per cycle, sustained, while m_tready stays high.
// Pipeline: on s_ acceptance the issue stage reads the previous row's result
//   from the row store RAM (registered read); the compute stage then adds the
//   cell to the chosen predecessor, writes the row store and loads the output
//   register.
// Stall: while m_tready is low, the output word holds and the compute stage
//   keeps one more cell; after that s_tready drops until the output is taken.
//   With m_tready high, s_tready is high.
// Reset: registers go to grid_size 5, neighbor_mode 0, both counters and the
//   left and diagonal sums to zero, the pipeline empties. The row store is not
//   cleared; every entry in use is written in the top row before it is used.
module grid_max_path_sum_core
    import gmps_pkg::*;
#(
    parameter int MAX_SIZE  = gmps_pkg::MAX_SIZE_DEF,
    parameter int SUM_WIDTH = gmps_pkg::SUM_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gmps_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [gmps_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [gmps_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready,
    // Cell input: tdata[15:0] cell_value
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [15:0]                           s_tdata,
    // Result output: tdata[SUM_WIDTH-1:0] path_sum, upper bits zero; tlast grid_done
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SUM_WIDTH+7)/8)*8-1:0]        m_tdata,
    output logic                                  m_tlast
);

    localparam int AW      = $clog2(MAX_SIZE);
    localparam int SZW     = $clog2(MAX_SIZE + 1);
    localparam int CMPW    = (SZW > GRID_SIZE_WIDTH) ? SZW : GRID_SIZE_WIDTH;
    localparam int TDATA_W = ((SUM_WIDTH + 7) / 8) * 8;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GRID_SIZE_WIDTH-1:0] grid_size_reg;
    gmps_mode_t                 mode_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_SIZE_RESET;
            mode_reg      <= gmps_mode_t'(MODE_RESET);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_GRID_SIZE:     grid_size_reg <= pwdata[GRID_SIZE_WIDTH-1:0];
                REG_NEIGHBOR_MODE: mode_reg      <= gmps_mode_t'(pwdata[0]);
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRID_SIZE:     prdata = APB_DATA_WIDTH'(grid_size_reg);
            REG_NEIGHBOR_MODE: prdata = APB_DATA_WIDTH'(mode_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Issue stage: position counters and row store read
    // ------------------------------------------------------------------
    logic [AW-1:0]   col_reg, col_next;
    logic [AW-1:0]   row_reg, row_next;
    logic [CMPW-1:0] size_ext, size_eff, size_last;
    logic            wrap;
    logic [AW-1:0]   pos_x, pos_y;
    logic            x_last, y_last;
    logic            s_accept;

    // Clamp grid_size into 1..MAX_SIZE
    always_comb begin
        size_ext = CMPW'(grid_size_reg);
        if (size_ext == '0) begin
            size_eff = CMPW'(1);
        end else if (size_ext > CMPW'(MAX_SIZE)) begin
            size_eff = CMPW'(MAX_SIZE);
        end else begin
            size_eff = size_ext;
        end
        size_last = size_eff - CMPW'(1);
    end

    // Restart at the origin when a counter lies beyond the current size
    always_comb begin
        wrap   = (CMPW'(col_reg) >= size_eff) || (CMPW'(row_reg) >= size_eff);
        pos_x  = wrap ? '0 : col_reg;
        pos_y  = wrap ? '0 : row_reg;
        x_last = (CMPW'(pos_x) == size_last);
        y_last = (CMPW'(pos_y) == size_last);
        if (x_last) begin
            col_next = '0;
            row_next = y_last ? '0 : pos_y + AW'(1);
        end else begin
            col_next = pos_x + AW'(1);
            row_next = pos_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage
    // ------------------------------------------------------------------
    logic                          s1_valid_reg;
    logic signed [CELL_WIDTH-1:0]  s1_cell_reg;
    logic [AW-1:0]                 s1_addr_reg;
    gmps_ctl_t                     s1_ctl_reg;
    logic                          s1_adv;

    logic signed [SUM_WIDTH-1:0]   left_reg;
    logic signed [SUM_WIDTH-1:0]   diag_reg;
    logic [SUM_WIDTH-1:0]          up_raw;
    logic signed [SUM_WIDTH-1:0]   up_sum;
    logic signed [SUM_WIDTH-1:0]   pred;
    logic signed [SUM_WIDTH:0]     sum_wide;
    logic signed [SUM_WIDTH-1:0]   sum_sat;

    logic                          m_valid_reg;
    logic [SUM_WIDTH-1:0]          m_data_reg;
    logic                          m_last_reg;

    // Compute stage moves on when the output register is free or being taken
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // Row store: read the upper neighbor on accept, write the new sum on advance.
    // Consecutive cells use different columns, so no write can overlap its read
    // except at grid size one, where the upper result is never used.
    gmps_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (MAX_SIZE)
    ) u_row_store (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (sum_sat),
        .re    (s_accept),
        .raddr (pos_x),
        .rdata (up_raw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cell_reg          <= s_tdata[CELL_WIDTH-1:0];
            s1_addr_reg          <= pos_x;
            s1_ctl_reg.first_col <= (pos_x == '0);
            s1_ctl_reg.first_row <= (pos_y == '0);
            s1_ctl_reg.last_cell <= x_last && y_last;
        end
    end

    assign up_sum = up_raw;

    // Pick the predecessor
    always_comb begin
        pred = '0;
        case (mode_reg)
            MODE_LEFT_UP: begin
                if (s1_ctl_reg.first_col && s1_ctl_reg.first_row) begin
                    pred = '0;
                end else if (s1_ctl_reg.first_col) begin
                    pred = up_sum;
                end else if (s1_ctl_reg.first_row) begin
                    pred = left_reg;
                end else begin
                    pred = (left_reg > up_sum) ? left_reg : up_sum;
                end
            end
            MODE_DIAG_ZERO: begin
                // Zero floor, then left, diagonal and upper where they exist
                if (!s1_ctl_reg.first_col && (left_reg > pred)) begin
                    pred = left_reg;
                end
                if (!s1_ctl_reg.first_col && !s1_ctl_reg.first_row && (diag_reg > pred)) begin
                    pred = diag_reg;
                end
                if (!s1_ctl_reg.first_row && (up_sum > pred)) begin
                    pred = up_sum;
                end
            end
            default: pred = '0;
        endcase
    end

    // Add one guard bit, then saturate
    always_comb begin
        sum_wide = (SUM_WIDTH+1)'(pred) + (SUM_WIDTH+1)'(s1_cell_reg);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
    end

    // Left and diagonal neighbors advance with each finished cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            diag_reg <= '0;
        end else if (s1_adv) begin
            left_reg <= sum_sat;
            diag_reg <= up_sum;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= sum_sat;
            m_last_reg <= s1_ctl_reg.last_cell;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/gmps_checker.sv */
`timescale 1ns / 1ps

module gmps_checker #(
    parameter int SUM_WIDTH = gmps_pkg::SUM_WIDTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [((SUM_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic                           m_tlast
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A ready receiver never back-pressures the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output ready");

    // A word on an empty output comes from a cell taken through the issue and compute stages
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output word without matching input");

endmodule

bind grid_max_path_sum_core gmps_checker #(
    .SUM_WIDTH (SUM_WIDTH)
) u_gmps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
